// ----- hw/rtl/annexb_access_unit_splitter_assert.svh -----
// Assertion macros for the Annex B access-unit splitter.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ANNEXB_ACCESS_UNIT_SPLITTER_ASSERT_SVH
`define ANNEXB_ACCESS_UNIT_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Hold cons in the same cycle as ante.
`define AUS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Hold cons in the cycle after ante.
`define AUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define AUS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define AUS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/aus_pkg.sv -----
// Shared types and constants of the Annex B access-unit splitter.
// No dependencies; imported by annexb_access_unit_splitter.
`default_nettype none

package aus_pkg;

  // Request and result codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // NAL header fields
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
  localparam logic [4:0] NAL_TYPE_AUD  = 5'd9;

  // Result queue sizing: one request yields at most MAX_RESULTS entries
  localparam int MAX_RESULTS = 6;
  localparam int SLOT_W      = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } aus_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       unit_first;
    logic       keyframe;
    logic       last;
  } aus_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/annexb_access_unit_splitter.sv -----
// Annex B access-unit splitter: takes one stream byte or flush request a
// cycle, forwards bytes tagged with their access unit and emits end records.
// Depends on aus_pkg and annexb_access_unit_splitter_assert.svh.
//
// Requests are taken at one per cycle while the input is not stalled. Each
// request is registered, then its results (none up to six: held start-code
// zeros, the 01 byte, the byte itself and end records) are built in one
// pass and written together into a 16-entry result queue that drains one
// result per cycle while the output is not stalled. The input register
// passes its request on only while ten or fewer queue entries are occupied,
// so the sustained rate is one request per cycle while the stream averages
// at most one result per byte; bursts of longer result runs stall the input
// until the queue drains. There are no configuration registers.
`default_nettype none
`include "annexb_access_unit_splitter_assert.svh"

module annexb_access_unit_splitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  aus_pkg::aus_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aus_pkg::aus_res_t out_data_o
);
  import aus_pkg::*;

  // Input register
  logic     in_valid_q;
  aus_req_t in_q;

  // Scanner state
  logic [1:0] zero_run_q, zero_run_d;
  logic       await_q, await_d;
  logic       long_q, long_d;
  logic       aud_q, aud_d;
  logic       idr_q, idr_d;
  logic       nonempty_q, nonempty_d;
  logic       nif_q, nif_d;

  // Result queue
  aus_res_t                queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0]     cnt_q;

  // Result list of the registered request
  logic              drain;
  logic              pop;
  logic [4:0]        nal_type;
  logic              is_zero, is_one;
  logic              e0, has1, hasb, e1;
  logic [1:0]        k;
  logic              first_flag;
  logic [SLOT_W-1:0] push_n, pos_one, pos_b;
  aus_res_t          slot [MAX_RESULTS];

  // Pass the request on when the queue has room for a full result burst
  assign drain      = in_valid_q && (cnt_q <= QUEUE_CW'(QUEUE_DEPTH - MAX_RESULTS));
  assign in_stall_o = in_valid_q && !drain;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Work out the shape of the result list and the next scanner state
  always_comb begin
    nal_type   = in_q.data_byte[4:0] & NAL_TYPE_MASK;
    is_zero    = (in_q.data_byte == 8'h00);
    is_one     = (in_q.data_byte == 8'h01);
    e0         = 1'b0;
    k          = 2'd0;
    has1       = 1'b0;
    hasb       = 1'b0;
    e1         = 1'b0;
    zero_run_d = zero_run_q;
    await_d    = await_q;
    long_d     = long_q;
    aud_d      = aud_q;
    idr_d      = idr_q;
    nonempty_d = nonempty_q;
    nif_d      = nif_q;

    if (in_q.req_type == REQ_FLUSH) begin
      // Release held bytes, close a non-empty unit, return to reset values
      if (await_q) begin
        k    = long_q ? 2'd3 : 2'd2;
        has1 = 1'b1;
      end else begin
        k = zero_run_q;
      end
      e1         = nonempty_q || await_q || (zero_run_q != 2'd0);
      zero_run_d = 2'd0;
      await_d    = 1'b0;
      long_d     = 1'b0;
      aud_d      = 1'b0;
      idr_d      = 1'b0;
      nonempty_d = 1'b0;
      nif_d      = 1'b1;
    end else if (await_q) begin
      // Header byte: a repeat delimiter closes the unit before its start code
      e0         = (nal_type == NAL_TYPE_AUD) && aud_q;
      k          = long_q ? 2'd3 : 2'd2;
      has1       = 1'b1;
      hasb       = !is_zero;
      zero_run_d = is_zero ? 2'd1 : 2'd0;
      await_d    = 1'b0;
      long_d     = 1'b0;
      aud_d      = aud_q || (nal_type == NAL_TYPE_AUD);
      idr_d      = (idr_q && !e0) || (nal_type == NAL_TYPE_IDR);
    end else if (is_zero) begin
      // Hold up to three zeros; a fourth releases the oldest
      if (zero_run_q != 2'd3) begin
        zero_run_d = zero_run_q + 2'd1;
      end else begin
        hasb = 1'b1;
      end
    end else if (is_one && zero_run_q[1]) begin
      // Start code found: wait for its header byte
      await_d    = 1'b1;
      long_d     = (zero_run_q == 2'd3);
      zero_run_d = 2'd0;
    end else begin
      // Ordinary byte: release held zeros then forward it
      k          = zero_run_q;
      hasb       = 1'b1;
      zero_run_d = 2'd0;
    end

    if (in_q.req_type == REQ_BYTE && (k != 2'd0 || has1 || hasb)) begin
      nonempty_d = 1'b1;
      nif_d      = 1'b0;
    end

    first_flag = e0 || nif_q;
    pos_one    = SLOT_W'(e0) + SLOT_W'(k);
    pos_b      = pos_one + SLOT_W'(has1);
    push_n     = pos_b + SLOT_W'(hasb) + SLOT_W'(e1);
  end

  // Fill each result slot from its position in the list
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot[i].kind       = KIND_DATA;
      slot[i].out_byte   = 8'h00;
      slot[i].unit_first = 1'b0;
      slot[i].keyframe   = 1'b0;
      slot[i].last       = (SLOT_W'(i) == push_n - SLOT_W'(1));
      if (e0 && i == 0) begin
        slot[i].kind     = KIND_END;
        slot[i].keyframe = idr_q;
      end else if (SLOT_W'(i) < pos_one) begin
        slot[i].unit_first = first_flag && (SLOT_W'(i) == SLOT_W'(e0));
      end else if (has1 && SLOT_W'(i) == pos_one) begin
        slot[i].out_byte   = 8'h01;
        slot[i].unit_first = first_flag && (SLOT_W'(i) == SLOT_W'(e0));
      end else if (hasb && SLOT_W'(i) == pos_b) begin
        slot[i].out_byte   = in_q.data_byte;
        slot[i].unit_first = first_flag && (SLOT_W'(i) == SLOT_W'(e0));
      end else begin
        slot[i].kind     = KIND_END;
        slot[i].keyframe = idr_q;
      end
    end
  end

  // Control state: input register, scanner state, queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      zero_run_q <= 2'd0;
      await_q    <= 1'b0;
      long_q     <= 1'b0;
      aud_q      <= 1'b0;
      idr_q      <= 1'b0;
      nonempty_q <= 1'b0;
      nif_q      <= 1'b1;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (drain) begin
        in_valid_q <= 1'b0;
      end
      if (drain) begin
        zero_run_q <= zero_run_d;
        await_q    <= await_d;
        long_q     <= long_d;
        aud_q      <= aud_d;
        idr_q      <= idr_d;
        nonempty_q <= nonempty_d;
        nif_q      <= nif_d;
        wr_ptr_q   <= wr_ptr_q + QUEUE_AW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      cnt_q <= cnt_q + (drain ? QUEUE_CW'(push_n) : QUEUE_CW'(0))
                     - (pop ? QUEUE_CW'(1) : QUEUE_CW'(0));
    end
  end

  // Payload: capture the request, write the result burst into the queue
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (drain && SLOT_W'(i) < push_n) begin
        queue_q[wr_ptr_q + QUEUE_AW'(i)] <= slot[i];
      end
    end
  end

  // Checks
  `AUS_ASSERT_IMPLIES(a_queue_bound, clk_i, rst_ni, 1'b1, cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
  `AUS_ASSERT_IMPLIES(a_no_zeros_while_await, clk_i, rst_ni, await_q, zero_run_q == 2'd0)
  `AUS_ASSERT_IMPLIES(a_unit_flags_agree, clk_i, rst_ni, 1'b1, nonempty_q == !nif_q)
  `AUS_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, drain && in_q.req_type == REQ_FLUSH, nif_q && !aud_q && !await_q && zero_run_q == 2'd0)
  `AUS_ASSERT_IMPLIES(a_room_on_drain, clk_i, rst_ni, drain, cnt_q + QUEUE_CW'(push_n) <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ----- verif/annexb_access_unit_splitter_tb.sv -----
// Self-checking testbench for the Annex B access-unit splitter: directed and
// random byte streams, a built-in prediction of forwarded bytes and end records.
// Depends on aus_pkg and the annexb_access_unit_splitter RTL.
module annexb_access_unit_splitter_tb;
  import aus_pkg::*;

  typedef struct {
    aus_req_t req;
    bit       hold_for_drain;
  } stream_item_t;

  localparam int RANDOM_ITEMS  = 430;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;

  logic     clk_i      = 1'b0;
  logic     rst_ni     = 1'b0;
  logic     in_valid   = 1'b0;
  logic     in_stall;
  aus_req_t in_data    = '0;
  logic     out_valid;
  logic     out_stall  = 1'b0;
  aus_res_t out_data;

  // Splitter state as predicted from the accepted requests
  logic [1:0] held_zeros      = 2'd0;
  bit         code_pending    = 1'b0;
  bit         pending_long    = 1'b0;
  bit         delim_seen      = 1'b0;
  bit         idr_in_unit     = 1'b0;
  bit         unit_has_bytes  = 1'b0;
  bit         unit_start_next = 1'b1;

  aus_res_t     step_results[$];
  aus_res_t     expected_results[$];
  stream_item_t stream_items[$];

  bit          drain_next   = 1'b0;
  int          total_items  = 0;
  int          accepted     = 0;
  int          idle_phase   = 0;
  int          errors       = 0;
  int unsigned cycles       = 0;

  annexb_access_unit_splitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Append one result to the list of the current request
  function automatic void append_step_result(aus_res_t r);
    step_results = {step_results, r};
  endfunction

  // Forward one byte into the current unit
  function automatic void forward_byte(logic [7:0] b);
    aus_res_t r;
    r = '{kind: KIND_DATA, out_byte: b, unit_first: unit_start_next, keyframe: 1'b0,
          last: 1'b0};
    append_step_result(r);
    unit_start_next = 1'b0;
    unit_has_bytes  = 1'b1;
  endfunction

  // Emit the end record of the current unit
  function automatic void close_unit();
    aus_res_t r;
    r = '{kind: KIND_END, out_byte: 8'h00, unit_first: 1'b0, keyframe: idr_in_unit,
          last: 1'b0};
    append_step_result(r);
    idr_in_unit     = 1'b0;
    unit_has_bytes  = 1'b0;
    unit_start_next = 1'b1;
  endfunction

  // Release held zeros or a whole pending start code
  function automatic void release_held();
    if (code_pending) begin
      repeat (pending_long ? 3 : 2) forward_byte(8'h00);
      forward_byte(8'h01);
    end else begin
      repeat (held_zeros) forward_byte(8'h00);
    end
    held_zeros   = 2'd0;
    code_pending = 1'b0;
    pending_long = 1'b0;
  endfunction

  // Scan a byte for start codes; only the last three zeros stay held
  function automatic void scan_byte(logic [7:0] b);
    if (b == 8'h00) begin
      if (held_zeros < 2'd3) held_zeros++;
      else forward_byte(8'h00);
    end else if (b == 8'h01 && held_zeros >= 2'd2) begin
      pending_long = (held_zeros == 2'd3);
      code_pending = 1'b1;
      held_zeros   = 2'd0;
    end else begin
      release_held();
      forward_byte(b);
    end
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void predict_request(aus_req_t r);
    logic [4:0] nal_type;
    step_results.delete();
    nal_type = r.data_byte[4:0] & NAL_TYPE_MASK;
    if (r.req_type == REQ_FLUSH) begin
      release_held();
      if (unit_has_bytes) close_unit();
      delim_seen      = 1'b0;
      idr_in_unit     = 1'b0;
      unit_has_bytes  = 1'b0;
      unit_start_next = 1'b1;
    end else if (code_pending) begin
      // a delimiter after the first closes the unit ahead of its start code
      if (nal_type == NAL_TYPE_AUD) begin
        if (delim_seen) close_unit();
        delim_seen = 1'b1;
      end
      if (nal_type == NAL_TYPE_IDR) idr_in_unit = 1'b1;
      release_held();
      scan_byte(r.data_byte);
    end else begin
      scan_byte(r.data_byte);
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    expected_results = {expected_results, step_results};
  endfunction

  // Stimulus building
  function automatic void add_item(logic req, logic [7:0] b);
    stream_item_t item;
    item.req.req_type  = req;
    item.req.data_byte = b;
    item.hold_for_drain = drain_next;
    drain_next = 1'b0;
    stream_items = {stream_items, item};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_item(REQ_BYTE, b);
  endfunction

  function automatic void add_flush();
    add_item(REQ_FLUSH, 8'($urandom_range(255)));
  endfunction

  function automatic void add_start_code(bit long_code);
    if (long_code) add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
  endfunction

  // Payload bytes lean towards zeros and 01 to provoke false start codes
  function automatic logic [7:0] payload_byte();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return 8'h00;
    if (pick == 2) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  function automatic void build_stimulus();
    int          directed_items;
    int unsigned pick;
    logic [2:0]  upper;
    logic [7:0]  header;
    // flush on an empty unit, then a leading byte before the first delimiter
    add_flush();
    add_byte(8'hff);
    // first delimiter on a short code, then an IDR slice on a long code
    add_start_code(1'b0);
    add_byte(8'h09);
    add_start_code(1'b1);
    add_byte(8'h65);
    // four zeros release the oldest one; the second delimiter closes the unit
    add_byte(8'h00);
    add_start_code(1'b1);
    add_byte(8'h29);
    // header byte of zero starts a new zero run, which forms the next code
    add_start_code(1'b0);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'he9);
    // flush with a start code still pending
    add_start_code(1'b0);
    add_flush();
    directed_items = stream_items.size();
    drain_next = 1'b1;

    while (stream_items.size() < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(39) == 0) drain_next = 1'b1;
      pick = $urandom_range(99);
      if (pick < 78) begin
        // well-formed NAL unit with random header and payload
        add_start_code($urandom_range(1) == 1);
        upper = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 35) header = {upper, NAL_TYPE_AUD};
        else if (pick < 55) header = {upper, NAL_TYPE_IDR};
        else header = 8'($urandom_range(255));
        add_byte(header);
        repeat ($urandom_range(6)) add_byte(payload_byte());
      end else if (pick < 87) begin
        // noise
        repeat ($urandom_range(5, 1)) add_byte(8'($urandom_range(255)));
      end else if (pick < 95) begin
        // broken sequence: long zero run, maybe a 01, then a flush or a byte
        repeat ($urandom_range(6, 3)) add_byte(8'h00);
        if ($urandom_range(1) == 1) add_byte(8'h01);
        if ($urandom_range(1) == 1) add_flush();
        else add_byte(payload_byte());
      end else begin
        add_flush();
      end
    end
    total_items = stream_items.size();
  endfunction

  // Driver: predict accepted requests, then offer the next one or idle
  always @(posedge clk_i) begin
    stream_item_t item;
    int           send_idle_pct;
    send_idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 57 : 0;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        accepted++;
        idle_phase <= (accepted * 3) / total_items;
      end
      if (!in_valid || !in_stall) begin
        if (stream_items.size() == 0 ||
            (stream_items[0].hold_for_drain && expected_results.size() != 0) ||
            $urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          item = stream_items.pop_front();
          in_valid <= 1'b1;
          in_data  <= item.req;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    aus_res_t want;
    int       recv_idle_pct;
    recv_idle_pct = (idle_phase == 0) ? 57 : (idle_phase == 1) ? 34 : 0;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: kind=%0d byte=%02h first=%0d key=%0d last=%0d",
                   $time, out_data.kind, out_data.out_byte, out_data.unit_first,
                   out_data.keyframe, out_data.last);
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind !== want.kind || out_data.out_byte !== want.out_byte ||
              out_data.unit_first !== want.unit_first ||
              out_data.keyframe !== want.keyframe || out_data.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d byte=%02h first=%0d key=%0d last=%0d",
                     $time, want.kind, want.out_byte, want.unit_first, want.keyframe,
                     want.last);
            $display("%0t:          actual   kind=%0d byte=%02h first=%0d key=%0d last=%0d",
                     $time, out_data.kind, out_data.out_byte, out_data.unit_first,
                     out_data.keyframe, out_data.last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL annexb_access_unit_splitter");
      $finish;
    end
  end

  // Hold reset, wait for the stream to drain, then give the verdict
  initial begin
    build_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (stream_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS annexb_access_unit_splitter");
    end else begin
      $display("FAIL annexb_access_unit_splitter");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/aus_pkg.sv
hw/rtl/annexb_access_unit_splitter.sv
verif/annexb_access_unit_splitter_tb.sv
